// ===== design/ugnt_pkg.sv =====
// Shared types and codes for the uniform grid neighbor table.
package ugnt_pkg;

   // Command codes.
   localparam logic [2:0] REQ_CLEAR      = 3'd0;
   localparam logic [2:0] REQ_REGISTER   = 3'd1;
   localparam logic [2:0] REQ_UPDATE     = 3'd2;
   localparam logic [2:0] REQ_UNREGISTER = 3'd3;
   localparam logic [2:0] REQ_QUERY      = 3'd4;

   // Smallest cell edge, 1.0 in Q16.16.
   localparam logic [31:0] CELL_MIN = 32'h0001_0000;
   localparam logic [31:0] CELL_RESET = 32'h0040_0000;

   // One stored agent entry.
   typedef struct packed {
      logic [15:0] handle;
      logic [15:0] cell_x;
      logic [15:0] cell_y;
      logic [31:0] order;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ===== design/ugnt_ram.sv =====
// Generic single-port-write, registered-read RAM.
module ugnt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/ugnt_cell_div.sv =====
// Sequential floor division of a signed Q16.16 position by the cell size.
module ugnt_cell_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] pos,
   input  logic [31:0] edge_len,
   output logic        done,
   output logic [15:0] cell_idx
);
   import ugnt_pkg::*;

   logic [31:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] div_ff, div_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic [32:0] rem_sh;
   logic [31:0] mag;
   logic [31:0] q_fl;

   always_comb begin
      mag    = pos[31] ? (~pos + 32'd1) : pos;
      rem_sh = {rem_ff[31:0], quo_ff[31]};
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      if (start) begin
         quo_in = mag;
         rem_in = '0;
         div_in = (edge_len < CELL_MIN) ? CELL_MIN : edge_len;
         neg_in = pos[31];
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff && cnt_ff != 6'd32) begin
         // one restoring step: shift in a dividend bit, subtract if it fits
         if (rem_sh >= {1'b0, div_ff}) begin
            rem_in = rem_sh - {1'b0, div_ff};
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
   end

   // round toward minus infinity for negative positions
   assign q_fl = !neg_ff ? quo_ff : ((rem_ff != '0) ? ~quo_ff : (~quo_ff + 32'd1));
   assign cell_idx = q_fl[15:0];
   assign done = run_ff && (cnt_ff == 6'd32);

endmodule

// ===== design/uniform_grid_neighbor_table_top.sv =====
// Top level of the uniform grid neighbor table.
//
// The block tracks up to MAX_AGENTS agents, each stored in one RAM entry with
// its handle, grid cell and arrival stamp; valid bits live in flip-flops and
// a clear command drops them all at once. One command is worked at a time
// and req_stall stays high until its last response word is loaded into the
// output register. Register, update and query first run two 32-step
// dividers to find the cell of the position. Register, update and
// unregister then sweep the table once, one RAM read per cycle, and finish
// in a final step. A neighbor query sweeps the table once per listed agent
// plus one final sweep, each sweep picking the next agent in (dx, dy,
// arrival, entry) order. Clear and unknown commands go straight to the
// finish step. The response register lets a new command be taken while the
// previous response word waits on rsp_stall.
module uniform_grid_neighbor_table_top #(
   parameter int MAX_AGENTS = 64,
   parameter int MAX_RANGE  = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [15:0] req_agent_handle,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic [2:0]  req_range_cells,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic        rsp_found,
   output logic [15:0] rsp_neighbor_handle,
   output logic        rsp_last
);
   import ugnt_pkg::*;

   localparam int IW = $clog2(MAX_AGENTS);
   localparam int OW = $clog2(2 * MAX_RANGE + 2);
   localparam int KW = 2 * OW + 32 + IW;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_DIV  = 6'b000010,
      S_SCAN = 6'b000100,
      S_ACT  = 6'b001000,
      S_PASS = 6'b010000,
      S_HOLD = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [31:0] edge_len_ff, edge_len_in;
   logic [2:0]  cmd_type_ff, cmd_type_in;
   logic [15:0] cmd_handle_ff, cmd_handle_in;
   logic [4:0]  cmd_range_ff, cmd_range_in;

   logic [MAX_AGENTS-1:0] valid_ff, valid_in;
   logic [31:0] arrival_ff, arrival_in;

   logic [IW:0]   scan_cnt_ff, scan_cnt_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;

   logic          match_ff, match_in;
   logic [IW-1:0] match_idx_ff, match_idx_in;
   logic [15:0]   match_cx_ff, match_cx_in;
   logic [15:0]   match_cy_ff, match_cy_in;
   logic          free_ff, free_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;

   logic          have_prev_ff, have_prev_in;
   logic [KW-1:0] prev_key_ff, prev_key_in;
   logic          best_vld_ff, best_vld_in;
   logic [KW-1:0] best_key_ff, best_key_in;
   logic [15:0]   best_handle_ff, best_handle_in;
   logic          pend_vld_ff, pend_vld_in;
   logic [15:0]   pend_handle_ff, pend_handle_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_status_ff, rsp_status_in;
   logic          rsp_found_ff, rsp_found_in;
   logic [15:0]   rsp_handle_ff, rsp_handle_in;
   logic          rsp_last_ff, rsp_last_in;

   logic                div_start;
   logic                div_done_x, div_done_y;
   logic [15:0]         cell_x, cell_y;
   logic                ram_we;
   logic [IW-1:0]       ram_waddr;
   entry_type           ram_wdata;
   logic [ENTRY_W-1:0]  ram_rdata;
   entry_type           rd_entry;
   logic                req_take, out_free, scan_start, scan_end;
   logic [16:0]         dx, dy, dxb, dyb, rng;
   logic                in_range;
   logic [KW-1:0]       key;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rd_entry  = entry_type'(ram_rdata);
   assign scan_end  = (scan_cnt_ff == (IW + 1)'(MAX_AGENTS)) && !rd_vld_ff;

   // Offsets of the entry just read from the query cell, biased to unsigned.
   always_comb begin
      dx  = {rd_entry.cell_x[15], rd_entry.cell_x} - {cell_x[15], cell_x};
      dy  = {rd_entry.cell_y[15], rd_entry.cell_y} - {cell_y[15], cell_y};
      rng = {12'd0, cmd_range_ff};
      in_range = ($signed(dx) >= -$signed(rng)) && ($signed(dx) <= $signed(rng)) &&
                 ($signed(dy) >= -$signed(rng)) && ($signed(dy) <= $signed(rng));
      dxb = dx + 17'(MAX_RANGE);
      dyb = dy + 17'(MAX_RANGE);
      key = {dxb[OW-1:0], dyb[OW-1:0], rd_entry.order, rd_idx_ff};
   end

   always_comb begin
      state_in       = state_ff;
      edge_len_in    = csr_we ? csr_wdata : edge_len_ff;
      cmd_type_in    = cmd_type_ff;
      cmd_handle_in  = cmd_handle_ff;
      cmd_range_in   = cmd_range_ff;
      valid_in       = valid_ff;
      arrival_in     = arrival_ff;
      scan_cnt_in    = scan_cnt_ff;
      rd_vld_in      = 1'b0;
      rd_idx_in      = scan_cnt_ff[IW-1:0];
      match_in       = match_ff;
      match_idx_in   = match_idx_ff;
      match_cx_in    = match_cx_ff;
      match_cy_in    = match_cy_ff;
      free_in        = free_ff;
      free_idx_in    = free_idx_ff;
      have_prev_in   = have_prev_ff;
      prev_key_in    = prev_key_ff;
      best_vld_in    = best_vld_ff;
      best_key_in    = best_key_ff;
      best_handle_in = best_handle_ff;
      pend_vld_in    = pend_vld_ff;
      pend_handle_in = pend_handle_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_handle_in  = rsp_handle_ff;
      rsp_last_in    = rsp_last_ff;
      div_start      = 1'b0;
      scan_start     = 1'b0;
      ram_we         = 1'b0;
      ram_waddr      = match_idx_ff;
      ram_wdata      = '{handle: cmd_handle_ff, cell_x: cell_x, cell_y: cell_y,
                         order: arrival_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cmd_type_in   = req_type;
               cmd_handle_in = req_agent_handle;
               // saturate the radius
               cmd_range_in  = ({2'b00, req_range_cells} > 5'(MAX_RANGE)) ?
                               5'(MAX_RANGE) : {2'b00, req_range_cells};
               have_prev_in  = 1'b0;
               pend_vld_in   = 1'b0;
               if (req_type == REQ_REGISTER || req_type == REQ_UPDATE ||
                   req_type == REQ_QUERY) begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end else if (req_type == REQ_UNREGISTER) begin
                  scan_start = 1'b1;
                  state_in   = S_SCAN;
               end else begin
                  state_in = S_ACT;
               end
            end
         end
         S_DIV: begin
            if (div_done_x && div_done_y) begin
               scan_start = 1'b1;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            // issue one read per cycle, look at the word read last cycle
            if (scan_cnt_ff != (IW + 1)'(MAX_AGENTS)) begin
               rd_vld_in   = 1'b1;
               scan_cnt_in = scan_cnt_ff + (IW + 1)'(1);
            end
            if (rd_vld_ff) begin
               if (valid_ff[rd_idx_ff]) begin
                  if (!match_ff && rd_entry.handle == cmd_handle_ff) begin
                     match_in     = 1'b1;
                     match_idx_in = rd_idx_ff;
                     match_cx_in  = rd_entry.cell_x;
                     match_cy_in  = rd_entry.cell_y;
                  end
                  if (in_range && (!have_prev_ff || key > prev_key_ff) &&
                      (!best_vld_ff || key < best_key_ff)) begin
                     best_vld_in    = 1'b1;
                     best_key_in    = key;
                     best_handle_in = rd_entry.handle;
                  end
               end else if (!free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
            end
            if (scan_end) begin
               state_in = (cmd_type_ff == REQ_QUERY) ? S_PASS : S_ACT;
            end
         end
         S_ACT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = 1'b0;
               rsp_found_in  = 1'b0;
               rsp_handle_in = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
               unique case (cmd_type_ff) inside
                  REQ_CLEAR: begin
                     valid_in   = '0;
                     arrival_in = '0;
                  end
                  REQ_REGISTER, REQ_UPDATE: begin
                     if (match_ff) begin
                        if (match_cx_ff != cell_x || match_cy_ff != cell_y) begin
                           ram_we     = 1'b1;
                           arrival_in = arrival_ff + 32'd1;
                        end
                     end else if (cmd_type_ff == REQ_REGISTER) begin
                        if (free_ff) begin
                           ram_we              = 1'b1;
                           ram_waddr           = free_idx_ff;
                           valid_in[free_idx_ff] = 1'b1;
                           arrival_in          = arrival_ff + 32'd1;
                        end else begin
                           rsp_status_in = 1'b1;
                        end
                     end
                  end
                  REQ_UNREGISTER: begin
                     if (match_ff) begin
                        valid_in[match_idx_ff] = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_PASS: begin
            if (best_vld_ff) begin
               if (!pend_vld_ff) begin
                  // first hit: hold it until we know whether it is the last
                  pend_vld_in    = 1'b1;
                  pend_handle_in = best_handle_ff;
                  have_prev_in   = 1'b1;
                  prev_key_in    = best_key_ff;
                  scan_start     = 1'b1;
                  state_in       = S_SCAN;
               end else if (out_free) begin
                  rsp_valid_in   = 1'b1;
                  rsp_status_in  = 1'b0;
                  rsp_found_in   = 1'b1;
                  rsp_handle_in  = pend_handle_ff;
                  rsp_last_in    = 1'b0;
                  pend_handle_in = best_handle_ff;
                  have_prev_in   = 1'b1;
                  prev_key_in    = best_key_ff;
                  scan_start     = 1'b1;
                  state_in       = S_SCAN;
               end
            end else begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            // nothing left: emit the held hit, or the empty word
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = 1'b0;
               rsp_found_in  = pend_vld_ff;
               rsp_handle_in = pend_vld_ff ? pend_handle_ff : 16'd0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (scan_start) begin
         scan_cnt_in = '0;
         rd_vld_in   = 1'b0;
         match_in    = 1'b0;
         free_in     = 1'b0;
         best_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         edge_len_ff  <= CELL_RESET;
         valid_ff     <= '0;
         arrival_ff   <= '0;
         scan_cnt_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         match_ff     <= 1'b0;
         free_ff      <= 1'b0;
         have_prev_ff <= 1'b0;
         best_vld_ff  <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         edge_len_ff  <= edge_len_in;
         valid_ff     <= valid_in;
         arrival_ff   <= arrival_in;
         scan_cnt_ff  <= scan_cnt_in;
         rd_vld_ff    <= rd_vld_in;
         match_ff     <= match_in;
         free_ff      <= free_in;
         have_prev_ff <= have_prev_in;
         best_vld_ff  <= best_vld_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_type_ff    <= cmd_type_in;
      cmd_handle_ff  <= cmd_handle_in;
      cmd_range_ff   <= cmd_range_in;
      rd_idx_ff      <= rd_idx_in;
      match_idx_ff   <= match_idx_in;
      match_cx_ff    <= match_cx_in;
      match_cy_ff    <= match_cy_in;
      free_idx_ff    <= free_idx_in;
      prev_key_ff    <= prev_key_in;
      best_key_ff    <= best_key_in;
      best_handle_ff <= best_handle_in;
      pend_handle_ff <= pend_handle_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_last_ff    <= rsp_last_in;
   end

   ugnt_cell_div u_div_x (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .pos       (req_pos_x),
      .edge_len  (edge_len_ff),
      .done      (div_done_x),
      .cell_idx  (cell_x)
   );

   ugnt_cell_div u_div_y (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .pos       (req_pos_y),
      .edge_len  (edge_len_ff),
      .done      (div_done_y),
      .cell_idx  (cell_y)
   );

   ugnt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_AGENTS)
   ) u_entry_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (scan_cnt_ff[IW-1:0]),
      .rdata (ram_rdata)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_found           = rsp_found_ff;
   assign rsp_neighbor_handle = rsp_handle_ff;
   assign rsp_last            = rsp_last_ff;

   // An accepted command always leaves idle on the next edge.
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff != S_IDLE))
      else $error("command accepted but block stayed idle");

   // A word with no agent closes its command.
   a_nofind_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> rsp_last)
      else $error("empty response word not marked last");

   // Table full only on a closing, non-query word.
   a_full_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_last && !rsp_found))
      else $error("bad table-full response word");

   // Table writes come only from the command finish step.
   a_write_act: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_ACT && out_free))
      else $error("table written outside finish step");

endmodule

// ===== sim/tb_uniform_grid_neighbor_table_top.sv =====
// Testbench for the uniform grid neighbor table: directed and random commands against a predictor.
`timescale 1ns / 100ps

module tb_uniform_grid_neighbor_table_top;
   import ugnt_pkg::*;

   localparam int AGENTS = 64;
   localparam int RANGE_MAX = 7;
   localparam logic [2:0] REQ_UNKNOWN = 3'd5;
   localparam logic [2:0] REQ_RESERVED = 3'd7;
   localparam int SETTLE_CYCLES = 40 + 66 * 66;
   localparam longint CYCLE_LIMIT = 10000000;

   // Response word as seen on the result channel.
   typedef struct packed {
      logic        status;
      logic        found;
      logic [15:0] handle;
      logic        last;
   } rsp_word_type;

   // Grid table predictor plus the queue of response words it predicts.
   class grid_scoreboard;
      bit           live[AGENTS];
      logic [15:0]  hnd[AGENTS];
      logic [15:0]  cx[AGENTS];
      logic [15:0]  cy[AGENTS];
      logic [31:0]  stamp[AGENTS];
      logic [31:0]  arrivals;
      logic [31:0]  cell_edge;
      rsp_word_type pending[$];
      int           errors;

      function void clear_all();
         foreach (live[i]) live[i] = 0;
         arrivals = 0;
         cell_edge = CELL_RESET;
         pending.delete();
         errors = 0;
      endfunction

      function logic [15:0] cell_of(logic signed [31:0] pos);
         longint p, c, q;
         p = pos;
         c = (cell_edge < CELL_MIN) ? longint'(CELL_MIN) : longint'(cell_edge);
         q = p / c;
         if (p % c != 0 && p < 0) q -= 1;
         return q[15:0];
      endfunction

      function int lookup(logic [15:0] h);
         for (int i = 0; i < AGENTS; i++)
            if (live[i] && hnd[i] == h) return i;
         return -1;
      endfunction

      // True if entry a is listed ahead of entry b.
      function bit ahead(int a, int b, int ax, int ay, int bx, int by);
         if (ax != bx) return ax < bx;
         if (ay != by) return ay < by;
         if (stamp[a] != stamp[b]) return stamp[a] < stamp[b];
         return a < b;
      endfunction

      function void note_request(logic [2:0] kind, logic [15:0] h, logic signed [31:0] px,
                                 logic signed [31:0] py, logic [2:0] rng);
         rsp_word_type w, hit;
         int idx, n, j, r, qx, qy, dx[AGENTS], dy[AGENTS], order_list[AGENTS];
         logic [15:0] nx, ny;
         w = '{status: 1'b0, found: 1'b0, handle: 16'd0, last: 1'b1};
         if (kind == REQ_QUERY) begin
            r = (rng > RANGE_MAX) ? RANGE_MAX : int'(rng);
            qx = int'($signed(cell_of(px)));
            qy = int'($signed(cell_of(py)));
            n = 0;
            for (int i = 0; i < AGENTS; i++) begin
               if (!live[i]) continue;
               dx[i] = int'($signed(cx[i])) - qx;
               dy[i] = int'($signed(cy[i])) - qy;
               if (dx[i] < -r || dx[i] > r || dy[i] < -r || dy[i] > r) continue;
               j = n;
               while (j > 0 && ahead(i, order_list[j-1], dx[i], dy[i],
                                     dx[order_list[j-1]], dy[order_list[j-1]])) begin
                  order_list[j] = order_list[j-1];
                  j--;
               end
               order_list[j] = i;
               n++;
            end
            if (n == 0) pending = {pending, w};
            for (int k = 0; k < n; k++) begin
               hit = '{status: 1'b0, found: 1'b1, handle: hnd[order_list[k]],
                       last: (k == n - 1)};
               pending = {pending, hit};
            end
            return;
         end
         case (kind)
            REQ_CLEAR: begin
               foreach (live[i]) live[i] = 0;
               arrivals = 0;
            end
            REQ_REGISTER, REQ_UPDATE: begin
               nx = cell_of(px);
               ny = cell_of(py);
               idx = lookup(h);
               if (idx >= 0) begin
                  if (cx[idx] != nx || cy[idx] != ny) begin
                     cx[idx] = nx; cy[idx] = ny; stamp[idx] = arrivals; arrivals++;
                  end
               end else if (kind == REQ_REGISTER) begin
                  idx = -1;
                  for (int i = 0; i < AGENTS && idx < 0; i++) if (!live[i]) idx = i;
                  if (idx >= 0) begin
                     live[idx] = 1; hnd[idx] = h; cx[idx] = nx; cy[idx] = ny;
                     stamp[idx] = arrivals; arrivals++;
                  end else w.status = 1'b1;
               end
            end
            REQ_UNREGISTER: begin
               idx = lookup(h);
               if (idx >= 0) live[idx] = 0;
            end
            default: ;
         endcase
         pending = {pending, w};
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type exp_w;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word status=%0d found=%0d handle=%h last=%0d", $time,
                     got.status, got.found, got.handle, got.last);
            errors++;
            return;
         end
         exp_w = pending.pop_front();
         if (got.status !== exp_w.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_w.status, got.status);
            errors++;
         end
         if (got.found !== exp_w.found) begin
            $display("%0t: found expected %0d actual %0d", $time, exp_w.found, got.found);
            errors++;
         end
         if (got.handle !== exp_w.handle) begin
            $display("%0t: handle expected %h actual %h", $time, exp_w.handle, got.handle);
            errors++;
         end
         if (got.last !== exp_w.last) begin
            $display("%0t: last expected %0d actual %0d", $time, exp_w.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [31:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_type = REQ_CLEAR;
   logic [15:0] req_agent_handle = '0;
   logic signed [31:0] req_pos_x = '0;
   logic signed [31:0] req_pos_y = '0;
   logic [2:0]  req_range_cells = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_status, rsp_found, rsp_last;
   logic [15:0] rsp_neighbor_handle;

   grid_scoreboard grid = new();
   longint cycles = 0;
   bit     hold_rsp = 1'b0;   // long receiver hold-off requested by stimulus
   bit     stall_mode = 1'b0;
   logic [15:0] pool[16];

   uniform_grid_neighbor_table_top i_dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_agent_handle(req_agent_handle), .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_range_cells(req_range_cells), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_found(rsp_found),
      .rsp_neighbor_handle(rsp_neighbor_handle), .rsp_last(rsp_last)
   );

   always #4 clock = ~clock;

   // Watchdog on total cycles.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Check each accepted response word at the edge that moves it.
   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         grid.check_word('{status: rsp_status, found: rsp_found,
                           handle: rsp_neighbor_handle, last: rsp_last});

   // Receiver stall pattern: alternate stall-free stretches with random stalls; stall fully during a hold-off.
   always @(posedge clock) begin
      if (hold_rsp) rsp_stall <= 1'b1;
      else if ($urandom_range(0, 63) == 0) begin
         stall_mode <= ~stall_mode;
         rsp_stall <= 1'b0;
      end else rsp_stall <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b0;
   end

   // Long receiver hold-off counted in cycles in its own process.
   task automatic hold_receiver(int n);
      hold_rsp = 1'b1;
      repeat (n) @(posedge clock);
      hold_rsp = 1'b0;
   endtask

   // Offer one word and hold it until accepted; valid stays high for back-to-back words,
   // otherwise drop valid and let the request lines idle.
   task automatic send_word(logic [2:0] kind, logic [15:0] h, logic signed [31:0] px,
                            logic signed [31:0] py, logic [2:0] rng, bit keep_valid);
      req_valid <= 1'b1;
      req_type <= kind;
      req_agent_handle <= h;
      req_pos_x <= px;
      req_pos_y <= py;
      req_range_cells <= rng;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      grid.note_request(kind, h, px, py, rng);
      if (!keep_valid) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Wait for every expected word, then let the block settle.
   task automatic drain();
      while (grid.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the cell size while idle.
   task automatic write_cell_size(logic [31:0] v);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      grid.cell_edge = v;
   endtask

   // Position near the tracked cluster so queries find neighbors; random when the cell edge exceeds 256.0.
   function automatic logic signed [31:0] near_pos();
      logic signed [31:0] c;
      c = (grid.cell_edge < CELL_MIN) ? CELL_MIN : grid.cell_edge;
      if (c > 32'h0100_0000) return $signed($urandom());
      return $signed(int'($urandom_range(0, 12)) - 6) * $signed(c) +
             $signed(32'($urandom_range(0, 32'h0000_ffff)));
   endfunction

   task automatic random_phase(int count, int handle_span);
      int burst, k;
      logic [2:0] kind;
      logic [15:0] h;
      bit more;
      k = 0;
      burst = 0;
      while (k < count) begin
         if (burst == 0) begin
            repeat ($urandom_range(0, 6)) @(posedge clock);
            burst = $urandom_range(1, 12);
         end
         case ($urandom_range(0, 99)) inside
            [0:1]:   kind = REQ_CLEAR;
            [2:37]:  kind = REQ_REGISTER;
            [38:55]: kind = REQ_UPDATE;
            [56:67]: kind = REQ_UNREGISTER;
            [68:97]: kind = REQ_QUERY;
            default: kind = 3'($urandom_range(5, 7));
         endcase
         h = ($urandom_range(0, 9) == 0) ? 16'($urandom()) :
             pool[$urandom_range(0, handle_span - 1)];
         burst--;
         k++;
         more = (burst != 0) && (k < count);
         if ($urandom_range(0, 7) == 0)
            send_word(kind, h, $signed($urandom()), $signed($urandom()),
                      3'($urandom()), more);
         else
            send_word(kind, h, near_pos(), near_pos(), 3'($urandom_range(0, 4)), more);
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      grid.clear_all();
      foreach (pool[i]) pool[i] = 16'($urandom());
      pool[0] = 16'h0000;
      pool[1] = 16'hffff;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, each command, empty query, unknown codes.
      send_word(REQ_QUERY, 16'd0, 32'sd0, 32'sd0, 3'd7, 1'b0);
      send_word(REQ_REGISTER, 16'h0000, 32'sh7fffffff, 32'sh80000000, 3'd0, 1'b1);
      send_word(REQ_REGISTER, 16'hffff, 32'sh80000000, 32'sh7fffffff, 3'd0, 1'b1);
      send_word(REQ_REGISTER, 16'h1234, -32'sd1, 32'sd0, 3'd0, 1'b1);
      send_word(REQ_REGISTER, 16'h1235, 32'sd0, -32'sd1, 3'd0, 1'b1);
      send_word(REQ_REGISTER, 16'h1234, -32'sd1, 32'sd0, 3'd0, 1'b1);
      send_word(REQ_UPDATE, 16'h1234, 32'sd100, 32'sd5, 3'd0, 1'b1);
      send_word(REQ_UPDATE, 16'h4321, 32'sd0, 32'sd0, 3'd0, 1'b1);
      send_word(REQ_QUERY, 16'h0, 32'sd0, 32'sd0, 3'd1, 1'b1);
      send_word(REQ_QUERY, 16'h0, 32'sh7fffffff, 32'sh80000000, 3'd7, 1'b1);
      send_word(REQ_QUERY, 16'h0, 32'sh80000000, 32'sh7fffffff, 3'd7, 1'b1);
      send_word(REQ_UNREGISTER, 16'h1235, 32'sd0, 32'sd0, 3'd0, 1'b1);
      send_word(REQ_UNREGISTER, 16'h7777, 32'sd0, 32'sd0, 3'd0, 1'b1);
      send_word(REQ_UNKNOWN, 16'hffff, 32'sd0, 32'sd0, 3'd7, 1'b1);
      send_word(REQ_RESERVED, 16'h0, 32'sd0, 32'sd0, 3'd0, 1'b1);
      send_word(REQ_QUERY, 16'h0, -32'sd1, 32'sd0, 3'd2, 1'b1);
      send_word(REQ_CLEAR, 16'h0, 32'sd0, 32'sd0, 3'd0, 1'b0);

      // Fill the table past capacity, then query with a range that covers every agent.
      write_cell_size(32'hffff_ffff);
      for (int i = 0; i < AGENTS + 2; i++)
         send_word(REQ_REGISTER, 16'(i * 3 + 1), $signed(32'($urandom())),
                   $signed(32'($urandom())), 3'd0, 1'b1);
      send_word(REQ_QUERY, 16'h0, 32'sd0, 32'sd0, 3'd7, 1'b0);

      // Sender pauses until all expected words have come.
      while (grid.pending.size() != 0) @(posedge clock);

      // Long receiver hold-off while the sender keeps offering words.
      fork
         hold_receiver(600);
         for (int i = 0; i < 6; i++)
            send_word(REQ_QUERY, 16'h0, $signed($urandom()), $signed($urandom()),
                      3'd7, i != 5);
      join

      write_cell_size(32'h0000_0000);
      send_word(REQ_CLEAR, 16'h0, 32'sd0, 32'sd0, 3'd0, 1'b0);
      random_phase(60, 8);
      write_cell_size(CELL_MIN);
      random_phase(60, 12);
      write_cell_size(32'h0003_8000);
      random_phase(80, 16);
      write_cell_size(CELL_RESET);
      random_phase(80, 16);
      write_cell_size(32'($urandom_range(32'h0001_0000, 32'h0080_0000)));
      random_phase(60, 16);

      drain();
      if (grid.errors == 0 && grid.pending.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
